// File: hdl/code_page_text_classifier_top_defines.svh
// Assertion macros shared by the classifier RTL.
`ifndef CODE_PAGE_TEXT_CLASSIFIER_TOP_DEFINES_SVH
`define CODE_PAGE_TEXT_CLASSIFIER_TOP_DEFINES_SVH

// Implication within the same cycle, checked out of reset.
`define CCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, checked out of reset.
`define CCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ccp_pkg.sv
// Package: widths, code page codes, byte class functions and shared types.
package ccp_pkg;

  localparam int unsigned CountWidth = 40;
  localparam int unsigned OutCountWidth = 40;
  localparam int unsigned ProdWidth = CountWidth + 7;

  localparam logic [15:0] CcsidEbcdic = 16'd1047;
  localparam logic [15:0] CcsidLatin  = 16'd819;
  localparam logic [15:0] CcsidUtf8   = 16'd1208;
  localparam logic [15:0] CcsidBinary = 16'd65535;

  localparam logic [6:0] MulMostly = 7'd105;
  localparam logic [6:0] MulTotal  = 7'd100;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [OutCountWidth-1:0] out_count_t;

  // Stream state after the byte just taken.
  typedef struct packed {
    count_t byte_cnt;
    count_t ebc_cnt;
    count_t asc_cnt;
    logic   utf8_bad;
    logic   utf8_idle;
    logic   saturated;
  } ccp_snap_t;

  function automatic logic in_rng(input logic [7:0] b, input logic [7:0] lo,
                                  input logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic logic is_ebcdic(input logic [7:0] b);
    return (b == 8'h05) || (b == 8'h0D) || (b == 8'h15) || (b == 8'h40) ||
           in_rng(b, 8'h4B, 8'h50) || in_rng(b, 8'h5A, 8'h61) ||
           in_rng(b, 8'h6B, 8'h6F) || in_rng(b, 8'h79, 8'h7F) ||
           in_rng(b, 8'h81, 8'h89) || in_rng(b, 8'h91, 8'h99) ||
           in_rng(b, 8'hA1, 8'hA9) || (b == 8'hAD) || (b == 8'hBD) ||
           in_rng(b, 8'hC0, 8'hC9) || in_rng(b, 8'hD0, 8'hD9) ||
           (b == 8'hE0) || in_rng(b, 8'hE2, 8'hE9) || in_rng(b, 8'hF0, 8'hF9);
  endfunction

  function automatic logic is_ascii(input logic [7:0] b);
    return in_rng(b, 8'h07, 8'h0A) || (b == 8'h0C) || (b == 8'h0D) ||
           (b == 8'h1B) || in_rng(b, 8'h20, 8'h7E);
  endfunction

  // Low bits of a counter, zero-extended when the counter is narrower.
  function automatic out_count_t out_count(input count_t c);
    logic [CountWidth+OutCountWidth-1:0] w;
    w = {{OutCountWidth{1'b0}}, c};
    return w[OutCountWidth-1:0];
  endfunction

endpackage

// File: hdl/ccp_in_if.sv
// Input channel: one byte item with its end-of-stream mark.
interface ccp_in_if import ccp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hdl/ccp_out_if.sv
// Output channel: one verdict item per stream.
interface ccp_out_if import ccp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [15:0] ccsid;
  logic       text_tag;
  logic       utf8_error;
  out_count_t ebcdic_valid_total;
  out_count_t ascii_valid_total;
  out_count_t byte_total;
  logic       count_overflow;

  modport source (output valid, output ccsid, output text_tag, output utf8_error,
                  output ebcdic_valid_total, output ascii_valid_total,
                  output byte_total, output count_overflow, input ready);
  modport sink   (input valid, input ccsid, input text_tag, input utf8_error,
                  input ebcdic_valid_total, input ascii_valid_total,
                  input byte_total, input count_overflow, output ready);
endinterface

// File: hdl/ccp_scan.sv
// Stream scanner: saturating byte counters and the UTF-8 sequence checker.
`include "code_page_text_classifier_top_defines.svh"

module ccp_scan import ccp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      acc_i,
  input  logic [7:0] data_byte_i,
  input  logic      last_byte_i,
  output ccp_snap_t snap_o
);

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhTwo1   = 3'd1,
    PhThree1 = 3'd2,
    PhThree2 = 3'd3,
    PhFour1  = 3'd4,
    PhFour2  = 3'd5,
    PhFour3  = 3'd6,
    PhBroken = 3'd7
  } phase_e;

  localparam count_t CountMax = '1;

  count_t byte_q, ebc_q, asc_q;
  count_t byte_d, ebc_d, asc_d;
  phase_e phase_q, phase_d;
  logic   bad_q, bad_d;
  logic   sat_q, sat_d;
  logic   cls_ebc, cls_asc, trail;
  logic   byte_full, ebc_full, asc_full;

  always_comb begin
    cls_ebc   = is_ebcdic(data_byte_i);
    cls_asc   = is_ascii(data_byte_i);
    trail     = in_rng(data_byte_i, 8'h80, 8'hBF);
    byte_full = (byte_q == CountMax);
    ebc_full  = (ebc_q == CountMax);
    asc_full  = (asc_q == CountMax);

    byte_d = byte_full ? byte_q : byte_q + count_t'(1);
    ebc_d  = (cls_ebc && !ebc_full) ? ebc_q + count_t'(1) : ebc_q;
    asc_d  = (cls_asc && !asc_full) ? asc_q + count_t'(1) : asc_q;
    sat_d  = sat_q || byte_full || (cls_ebc && ebc_full) || (cls_asc && asc_full);

    case (phase_q)
      PhIdle: begin
        if (cls_asc) phase_d = PhIdle;
        else if (in_rng(data_byte_i, 8'hC0, 8'hDF)) phase_d = PhTwo1;
        else if (in_rng(data_byte_i, 8'hE0, 8'hEF)) phase_d = PhThree1;
        else if (in_rng(data_byte_i, 8'hF0, 8'hF7)) phase_d = PhFour1;
        else phase_d = PhBroken;
      end
      PhTwo1:   phase_d = trail ? PhIdle   : PhBroken;
      PhThree1: phase_d = trail ? PhThree2 : PhBroken;
      PhThree2: phase_d = trail ? PhIdle   : PhBroken;
      PhFour1:  phase_d = trail ? PhFour2  : PhBroken;
      PhFour2:  phase_d = trail ? PhFour3  : PhBroken;
      PhFour3:  phase_d = trail ? PhIdle   : PhBroken;
      default:  phase_d = PhBroken;
    endcase
    bad_d = bad_q || (phase_d == PhBroken);

    snap_o.byte_cnt  = byte_d;
    snap_o.ebc_cnt   = ebc_d;
    snap_o.asc_cnt   = asc_d;
    snap_o.utf8_bad  = bad_d;
    snap_o.utf8_idle = (phase_d == PhIdle);
    snap_o.saturated = sat_d;
  end

  // A last byte hands its totals on and starts a fresh stream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q  <= '0;
      ebc_q   <= '0;
      asc_q   <= '0;
      phase_q <= PhIdle;
      bad_q   <= 1'b0;
      sat_q   <= 1'b0;
    end else if (acc_i) begin
      if (last_byte_i) begin
        byte_q  <= '0;
        ebc_q   <= '0;
        asc_q   <= '0;
        phase_q <= PhIdle;
        bad_q   <= 1'b0;
        sat_q   <= 1'b0;
      end else begin
        byte_q  <= byte_d;
        ebc_q   <= ebc_d;
        asc_q   <= asc_d;
        phase_q <= phase_d;
        bad_q   <= bad_d;
        sat_q   <= sat_d;
      end
    end
  end

  `CCP_ASSERT_NOW(a_bad_tracks_phase, 1'b1, (phase_q == PhBroken) == bad_q,
                  "utf8 error flag out of step with broken phase")
  `CCP_ASSERT_NOW(a_counts_bounded, 1'b1, (ebc_q <= byte_q) && (asc_q <= byte_q),
                  "class count exceeds byte count")
  `CCP_ASSERT_NEXT(a_clear_after_last, acc_i && last_byte_i,
                   (byte_q == '0) && !sat_q && !bad_q,
                   "stream state not cleared after last byte")

endmodule

// File: hdl/code_page_text_classifier_top.sv
// Top level: code page text classifier with a three-register verdict pipeline.
//
// Usage
//   in_i  : byte items (data_byte, last_byte), valid/ready. One byte can be taken
//           per cycle while ready is high; counters and UTF-8 checker update on each.
//   out_o : one verdict item per stream, produced only for a byte marked
//           last_byte. It carries the code page, text flag, UTF-8 error flag,
//           the three saturating totals and the overflow flag.
//   cfg_we_i / cfg_wdata_i : writes utf8_as_1208; write only while idle.
// Pipeline: after the edge that accepts the last byte, the verdict passes the
//   snapshot register, product register and output register in turn.
// Throughput: one byte per cycle while in_i.ready is high; counters update on each byte.
// Reset clears counters, the UTF-8 checker, the pipeline valids and the
//   register (UTF-8 text is then reported as 819).
// Stall: while out_o is held, non-last bytes keep flowing; verdicts queue
//   in the two inner registers and in_i.ready drops only when all three
//   verdict slots are full.
`include "code_page_text_classifier_top_defines.svh"

module code_page_text_classifier_top import ccp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  ccp_in_if.sink     in_i,
  ccp_out_if.source  out_o
);

  logic      cfg_q;
  logic      in_acc;
  ccp_snap_t snap;

  // Snapshot stage
  logic      s1_v_q;
  ccp_snap_t s1_q;
  // Product stage
  logic                 s2_v_q;
  logic [ProdWidth-1:0] e_mul_q, a_mul_q, t_mul_q;
  logic                 e_all_q, a_all_q, e_nz_q, a_nz_q, utf8_ok_q;
  logic                 s2_bad_q, s2_sat_q;
  out_count_t           s2_ebc_q, s2_asc_q, s2_byte_q;
  // Output stage
  logic        out_v_q;
  logic [15:0] ccsid_q;
  logic        text_q, bad_q, sat_q;
  out_count_t  ebc_q, asc_q, byte_q;

  logic out_free, s2_free, s1_free;
  logic [15:0] ccsid_d;
  logic        text_d;

  // Each slot frees when empty or when it moves on in this cycle.
  assign out_free  = !out_v_q || out_o.ready;
  assign s2_free   = !s2_v_q || out_free;
  assign s1_free   = !s1_v_q || s2_free;
  assign in_i.ready = s1_free;
  assign in_acc    = in_i.valid && s1_free;

  ccp_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .snap_o      (snap)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 1'b0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= in_acc && in_i.last_byte;
      if (s2_free) s2_v_q <= s1_v_q;
      if (out_free) out_v_q <= s2_v_q;
    end
  end

  // Snapshot of the stream totals, last byte included.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.last_byte) begin
      s1_q <= snap;
    end
  end

  // Scale counts for the mostly-one-class test: count*105 against total*100.
  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_free) begin
      e_mul_q   <= {7'd0, s1_q.ebc_cnt} * ProdWidth'(MulMostly);
      a_mul_q   <= {7'd0, s1_q.asc_cnt} * ProdWidth'(MulMostly);
      t_mul_q   <= {7'd0, s1_q.byte_cnt} * ProdWidth'(MulTotal);
      e_nz_q    <= (s1_q.ebc_cnt != '0);
      a_nz_q    <= (s1_q.asc_cnt != '0);
      e_all_q   <= (s1_q.ebc_cnt != '0) && (s1_q.ebc_cnt == s1_q.byte_cnt);
      a_all_q   <= (s1_q.asc_cnt != '0) && (s1_q.asc_cnt == s1_q.byte_cnt);
      utf8_ok_q <= !s1_q.utf8_bad && s1_q.utf8_idle;
      s2_bad_q  <= s1_q.utf8_bad;
      s2_sat_q  <= s1_q.saturated;
      s2_ebc_q  <= out_count(s1_q.ebc_cnt);
      s2_asc_q  <= out_count(s1_q.asc_cnt);
      s2_byte_q <= out_count(s1_q.byte_cnt);
    end
  end

  // Verdict priority: all EBCDIC, all ASCII, clean UTF-8, then mostly EBCDIC, mostly ASCII, else binary.
  always_comb begin
    if (e_all_q) begin
      ccsid_d = CcsidEbcdic;
      text_d  = 1'b1;
    end else if (a_all_q) begin
      ccsid_d = CcsidLatin;
      text_d  = 1'b1;
    end else if (a_nz_q && utf8_ok_q) begin
      ccsid_d = cfg_q ? CcsidUtf8 : CcsidLatin;
      text_d  = 1'b1;
    end else begin
      text_d = 1'b0;
      if (e_nz_q && (e_mul_q >= t_mul_q)) ccsid_d = CcsidEbcdic;
      else if (a_nz_q && (a_mul_q >= t_mul_q)) ccsid_d = CcsidLatin;
      else ccsid_d = CcsidBinary;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q && out_free) begin
      ccsid_q <= ccsid_d;
      text_q  <= text_d;
      bad_q   <= s2_bad_q;
      sat_q   <= s2_sat_q;
      ebc_q   <= s2_ebc_q;
      asc_q   <= s2_asc_q;
      byte_q  <= s2_byte_q;
    end
  end

  assign out_o.valid              = out_v_q;
  assign out_o.ccsid              = ccsid_q;
  assign out_o.text_tag           = text_q;
  assign out_o.utf8_error         = bad_q;
  assign out_o.ebcdic_valid_total = ebc_q;
  assign out_o.ascii_valid_total  = asc_q;
  assign out_o.byte_total         = byte_q;
  assign out_o.count_overflow     = sat_q;

  `CCP_ASSERT_NOW(a_stall_only_when_full, !in_i.ready, s1_v_q && s2_v_q && out_v_q,
                  "input stalled with a free verdict slot")
  `CCP_ASSERT_NOW(a_binary_not_text, out_v_q && text_q, ccsid_q != CcsidBinary,
                  "binary verdict tagged as text")
  `CCP_ASSERT_NOW(a_utf8_clean, out_v_q && (ccsid_q == CcsidUtf8), text_q && !bad_q,
                  "UTF-8 verdict on malformed or untagged stream")

endmodule
